/* src/wpd_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants for the windowed peak detector.
// Depends on nothing; used by windowed_peak_detector_top.
package wpd_pkg;

   localparam int SAMPLE_BITS     = 16;
   localparam int NUMBER_BITS     = 32;
   localparam int RADIUS_BITS     = 7;
   localparam int GAP_BITS        = 8;
   localparam int PROM_BITS       = 16;
   localparam int CSR_ADDR_BITS   = 2;
   localparam int CSR_DATA_BITS   = 16;
   localparam int RING_DEPTH_DEF  = 256;
   localparam int MAX_RADIUS_DEF  = 64;

   localparam logic [CSR_ADDR_BITS-1:0] CSR_WINDOW_RADIUS   = 2'd0;
   localparam logic [CSR_ADDR_BITS-1:0] CSR_REFRACTORY_GAP  = 2'd1;
   localparam logic [CSR_ADDR_BITS-1:0] CSR_MIN_PROMINENCE  = 2'd2;
   localparam logic [CSR_ADDR_BITS-1:0] CSR_INVERT_POLARITY = 2'd3;

   localparam logic STATUS_OK       = 1'b0;
   localparam logic STATUS_REJECTED = 1'b1;

   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] sample_value;
      logic [NUMBER_BITS-1:0]        sample_number;
   } req_type;

   typedef struct packed {
      logic                          status_code;
      logic                          peak_found;
      logic [NUMBER_BITS-1:0]        peak_number;
      logic signed [SAMPLE_BITS-1:0] peak_value;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_MULT,
      ST_CHECK
   } state_type;

endpackage

/* src/windowed_peak_detector_top.sv */
`timescale 1ns / 1ps
// Windowed peak detector: sample and index rings in two synchronous memories,
// a neighbour scan sequencer and the prominence and refractory checks.
// Depends on wpd_pkg for payload types, register indexes and states.
//
// Usage: each req transaction carries one sample and its index. Every
// accepted req transaction produces exactly one rsp transaction carrying a
// status, a peak flag and, when a peak is reported, the index and original
// value of the sample that lies R places behind the newest one.
// An index that does not increase is rejected with a status and stores
// nothing. Such a transaction, and one that arrives while the ring holds
// fewer than 2R+1 samples, has its result in the output register in the
// cycle after acceptance. A full window test stores the sample, reads the
// candidate and then its neighbour pairs through the two read ports of the
// sample memory, then finishes the sum, forms the scaled prominence
// product and compares. The next req transaction is taken as soon as the
// sequencer is idle and the output register is free or being drained, so a
// stalled receiver holds the block once one result waits.
// Reset clears the configuration to its defaults and empties the ring;
// the memories themselves need no clearing, the fill count covers them.
// The user must write configuration through the csr port only while the block is idle; the block does not enforce this.
module windowed_peak_detector_top #(
   parameter int RING_DEPTH = wpd_pkg::RING_DEPTH_DEF,
   parameter int MAX_RADIUS = wpd_pkg::MAX_RADIUS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  wpd_pkg::req_type                   req_data,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output wpd_pkg::rsp_type                   rsp_data,
   input  logic                               csr_we,
   input  logic [wpd_pkg::CSR_ADDR_BITS-1:0]  csr_addr,
   input  logic [wpd_pkg::CSR_DATA_BITS-1:0]  csr_wdata
);

   localparam int SB      = wpd_pkg::SAMPLE_BITS;
   localparam int NB      = wpd_pkg::NUMBER_BITS;
   localparam int AW      = $clog2(RING_DEPTH);
   localparam int R_MAX   = (MAX_RADIUS < (RING_DEPTH - 1) / 2) ?
                            MAX_RADIUS : (RING_DEPTH - 1) / 2;
   localparam int RW      = $clog2(R_MAX + 1);
   localparam int FW      = $clog2(RING_DEPTH + 1);
   localparam int OW      = SB + 1;
   localparam int PW      = OW + 1;
   localparam int SUM_W   = OW + $clog2(2 * R_MAX) + 1;
   localparam int PROM_W  = wpd_pkg::PROM_BITS;
   localparam int DIFF_W  = ((OW > PROM_W + 1) ? OW : PROM_W + 1) + 1;
   localparam int MUL_W   = DIFF_W + RW + 2;
   localparam int CMP_W   = (MUL_W > SUM_W) ? MUL_W : SUM_W;

   logic [wpd_pkg::RADIUS_BITS-1:0] radius_ff;
   logic [wpd_pkg::GAP_BITS-1:0]    gap_ff;
   logic [PROM_W-1:0]               prom_ff;
   logic                            invert_ff;

   logic [SB-1:0] sample_mem [RING_DEPTH];
   logic [NB-1:0] index_mem  [RING_DEPTH];
   logic [SB-1:0] rd_a_ff;
   logic [SB-1:0] rd_b_ff;
   logic [NB-1:0] cidx_ff;

   logic [AW-1:0] wp_ff;
   logic [FW-1:0] fill_ff;
   logic [NB-1:0] last_num_ff;
   logic          seen_ff;
   logic [NB-1:0] last_peak_ff;
   logic          peak_seen_ff;

   wpd_pkg::state_type state_ff;
   wpd_pkg::state_type state_in;

   logic [RW-1:0] k_ff;
   logic [RW-1:0] r_ff;
   logic [AW-1:0] left_ff;
   logic [AW-1:0] right_ff;
   logic          rd_valid_ff;
   logic          rd_cand_ff;

   logic signed [OW-1:0]    cand_ff;
   logic [SB-1:0]           cand_raw_ff;
   logic signed [SUM_W-1:0] sum_ff;
   logic                    fail_ff;
   logic signed [MUL_W-1:0] prod_ff;

   wpd_pkg::rsp_type rsp_ff;
   logic             rsp_valid_ff;

   logic          out_free;
   logic          req_fire;
   logic          reject;
   logic          short_window;
   logic          scan_issue;
   logic          check_load;
   logic          peak_ok;
   logic          gap_ok;
   logic [RW-1:0] r_eff;
   logic [FW-1:0] fill_next;
   logic [AW-1:0] cpos;
   logic [AW-1:0] wp_inc;
   logic [AW-1:0] left_dec;
   logic [AW-1:0] right_inc;

   logic signed [OW-1:0]     a_ext;
   logic signed [OW-1:0]     b_ext;
   logic signed [OW-1:0]     lv;
   logic signed [OW-1:0]     rv;
   logic signed [PW-1:0]     pair_sum;
   logic signed [DIFF_W-1:0] diff;
   logic signed [RW+1:0]     two_r;

   assign out_free = !rsp_valid_ff || rsp_ready;
   assign req_fire = req_valid && req_ready;
   assign reject   = seen_ff && (req_data.sample_number <= last_num_ff);

   always_comb begin
      if (32'(radius_ff) > 32'(R_MAX)) begin
         r_eff = RW'(R_MAX);
      end else begin
         r_eff = RW'(radius_ff);
      end
   end

   assign fill_next    = (fill_ff == FW'(RING_DEPTH)) ? fill_ff : fill_ff + FW'(1);
   assign short_window = (r_eff == '0) || (32'(fill_next) < 32'({r_eff, 1'b1}));
   assign cpos         = (wp_ff >= AW'(r_eff)) ? wp_ff - AW'(r_eff)
                                               : wp_ff + AW'(RING_DEPTH) - AW'(r_eff);
   assign wp_inc       = (wp_ff == AW'(RING_DEPTH - 1)) ? '0 : wp_ff + AW'(1);
   assign left_dec     = (left_ff == '0) ? AW'(RING_DEPTH - 1) : left_ff - AW'(1);
   assign right_inc    = (right_ff == AW'(RING_DEPTH - 1)) ? '0 : right_ff + AW'(1);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         wpd_pkg::ST_IDLE: begin
            if (req_fire && !reject && !short_window) begin
               state_in = wpd_pkg::ST_SCAN;
            end
         end
         wpd_pkg::ST_SCAN: begin
            if (k_ff == r_ff) begin
               state_in = wpd_pkg::ST_DRAIN;
            end
         end
         wpd_pkg::ST_DRAIN: state_in = wpd_pkg::ST_MULT;
         wpd_pkg::ST_MULT:  state_in = wpd_pkg::ST_CHECK;
         wpd_pkg::ST_CHECK: begin
            if (out_free) begin
               state_in = wpd_pkg::ST_IDLE;
            end
         end
         default: state_in = wpd_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      req_ready  = 1'b0;
      scan_issue = 1'b0;
      check_load = 1'b0;
      unique case (state_ff)
         wpd_pkg::ST_IDLE:  req_ready  = out_free;
         wpd_pkg::ST_SCAN:  scan_issue = 1'b1;
         wpd_pkg::ST_CHECK: check_load = out_free;
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         radius_ff <= wpd_pkg::RADIUS_BITS'(1);
         gap_ff    <= wpd_pkg::GAP_BITS'(1);
         prom_ff   <= '0;
         invert_ff <= 1'b0;
      end else if (csr_we) begin
         unique case (csr_addr)
            wpd_pkg::CSR_WINDOW_RADIUS:   radius_ff <= csr_wdata[wpd_pkg::RADIUS_BITS-1:0];
            wpd_pkg::CSR_REFRACTORY_GAP:  gap_ff    <= csr_wdata[wpd_pkg::GAP_BITS-1:0];
            wpd_pkg::CSR_MIN_PROMINENCE:  prom_ff   <= csr_wdata[PROM_W-1:0];
            wpd_pkg::CSR_INVERT_POLARITY: invert_ff <= csr_wdata[0];
            default: begin
               invert_ff <= invert_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire && !reject) begin
         sample_mem[wp_ff] <= req_data.sample_value;
         index_mem[wp_ff]  <= req_data.sample_number;
      end
      if (scan_issue) begin
         rd_a_ff <= sample_mem[left_ff];
         rd_b_ff <= sample_mem[right_ff];
      end
      if (scan_issue && (k_ff == '0)) begin
         cidx_ff <= index_mem[left_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= wpd_pkg::ST_IDLE;
         wp_ff        <= '0;
         fill_ff      <= '0;
         last_num_ff  <= '0;
         seen_ff      <= 1'b0;
         last_peak_ff <= '0;
         peak_seen_ff <= 1'b0;
         k_ff         <= '0;
         rd_valid_ff  <= 1'b0;
         rd_cand_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         rd_valid_ff <= scan_issue;
         rd_cand_ff  <= scan_issue && (k_ff == '0);
         if (req_fire && !reject) begin
            wp_ff       <= wp_inc;
            fill_ff     <= fill_next;
            last_num_ff <= req_data.sample_number;
            seen_ff     <= 1'b1;
            k_ff        <= '0;
         end else if (scan_issue) begin
            k_ff <= k_ff + RW'(1);
         end
         if (check_load && peak_ok) begin
            last_peak_ff <= cidx_ff;
            peak_seen_ff <= 1'b1;
         end
         if ((req_fire && (reject || short_window)) || check_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign a_ext    = OW'(signed'(rd_a_ff));
   assign b_ext    = OW'(signed'(rd_b_ff));
   assign lv       = invert_ff ? -a_ext : a_ext;
   assign rv       = invert_ff ? -b_ext : b_ext;
   assign pair_sum = PW'(lv) + PW'(rv);
   assign diff     = DIFF_W'(cand_ff) - DIFF_W'(signed'({1'b0, prom_ff}));
   assign two_r    = signed'({1'b0, r_ff, 1'b0});
   assign gap_ok   = !peak_seen_ff || ((cidx_ff - last_peak_ff) >= NB'(gap_ff));
   assign peak_ok  = !fail_ff && gap_ok && (CMP_W'(prod_ff) >= CMP_W'(sum_ff));

   always_ff @(posedge clock) begin
      if (req_fire && !reject && !short_window) begin
         r_ff     <= r_eff;
         left_ff  <= cpos;
         right_ff <= cpos;
      end else if (scan_issue) begin
         left_ff  <= left_dec;
         right_ff <= right_inc;
      end
      if (rd_valid_ff) begin
         if (rd_cand_ff) begin
            cand_ff     <= lv;
            cand_raw_ff <= rd_a_ff;
            sum_ff      <= '0;
            fail_ff     <= 1'b0;
         end else begin
            sum_ff  <= sum_ff + SUM_W'(pair_sum);
            fail_ff <= fail_ff || (cand_ff <= lv) || (cand_ff < rv);
         end
      end
      if (state_ff == wpd_pkg::ST_MULT) begin
         prod_ff <= MUL_W'(diff) * MUL_W'(two_r);
      end
      if (req_fire && (reject || short_window)) begin
         rsp_ff.status_code <= reject ? wpd_pkg::STATUS_REJECTED : wpd_pkg::STATUS_OK;
         rsp_ff.peak_found  <= 1'b0;
         rsp_ff.peak_number <= '0;
         rsp_ff.peak_value  <= '0;
      end else if (check_load) begin
         rsp_ff.status_code <= wpd_pkg::STATUS_OK;
         rsp_ff.peak_found  <= peak_ok;
         rsp_ff.peak_number <= peak_ok ? cidx_ff : '0;
         rsp_ff.peak_value  <= peak_ok ? signed'(cand_raw_ff) : '0;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_fill_bounded: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= FW'(RING_DEPTH))
      else $error("fill count exceeds ring depth");

   a_scan_bounded: assert property (@(posedge clock) disable iff (reset)
      (state_ff == wpd_pkg::ST_SCAN) |-> (k_ff <= r_ff))
      else $error("scan counter ran past the window radius");

   a_check_loads: assert property (@(posedge clock) disable iff (reset)
      check_load |=> (rsp_valid_ff && (state_ff == wpd_pkg::ST_IDLE)))
      else $error("window result was not loaded into the output register");

   a_peak_tracked: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.peak_found) |->
         (peak_seen_ff && (last_peak_ff == rsp_ff.peak_number)))
      else $error("reported peak does not match the refractory reference");

endmodule
